// ----- sv/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and
// disabled while reset is asserted.
`define TAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge and
// disabled while reset is asserted.
`define TAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/tafsm_pkg.sv -----
package tafsm_pkg;

  localparam int TempW  = 16;
  localparam int StateW = 4;
  localparam int CfgIdxW = 3;

  // Default depth of the queue between the classifier and the state unit.
  localparam int QueueDepthDefault = 2;

  // Alarm state codes.
  localparam logic [StateW-1:0] StNorm1   = 4'd0;
  localparam logic [StateW-1:0] StNorm3   = 4'd1;
  localparam logic [StateW-1:0] StWarnHi1 = 4'd2;
  localparam logic [StateW-1:0] StWarnHi2 = 4'd3;
  localparam logic [StateW-1:0] StCritHi  = 4'd4;
  localparam logic [StateW-1:0] StNorm2   = 4'd5;
  localparam logic [StateW-1:0] StWarnLo2 = 4'd6;
  localparam logic [StateW-1:0] StWarnLo1 = 4'd7;
  localparam logic [StateW-1:0] StCritLo  = 4'd8;

  localparam logic signed [TempW-1:0] TempMax = 16'sh7fff;
  localparam logic signed [TempW-1:0] TempMin = 16'sh8000;

  typedef enum logic [1:0] {
    LedNone = 2'd0,
    LedOff  = 2'd1,
    LedSlow = 2'd2,
    LedFast = 2'd3
  } led_e;

  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvLoWarn  = 3'd1,
    EvHiWarn  = 3'd2,
    EvLoAlarm = 3'd3,
    EvHiAlarm = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgEnable       = 3'd0,
    CfgHighCritical = 3'd1,
    CfgHighWarning  = 3'd2,
    CfgLowCritical  = 3'd3,
    CfgLowWarning   = 3'd4
  } cfg_reg_e;

  // Outcome of comparing one sample against the thresholds.
  typedef struct packed {
    logic enable;
    logic above_lc;   // sample > low_critical
    logic atmost_lw;  // sample <= low_warning
    logic below_hc;   // sample < high_critical
    logic atleast_hw; // sample >= high_warning
  } cls_t;

endpackage

// ----- sv/tafsm_if.sv -----
interface tafsm_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tafsm_pkg::TempW-1:0]    temperature;

  modport source (output valid, output temperature, input ready);
  modport sink   (input valid, input temperature, output ready);
endinterface

interface tafsm_result_if;
  logic                                  valid;
  logic                                  ready;
  tafsm_pkg::led_e                       led_command;
  tafsm_pkg::event_e                     event_code;
  logic [tafsm_pkg::StateW-1:0]          alarm_state;

  modport source (output valid, output led_command, output event_code,
                  output alarm_state, input ready);
  modport sink   (input valid, input led_command, input event_code,
                  input alarm_state, output ready);
endinterface

interface tafsm_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [tafsm_pkg::CfgIdxW-1:0]         index;
  logic [tafsm_pkg::TempW-1:0]           data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- sv/tafsm_front.sv -----
module tafsm_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  tafsm_cfg_if.sink            cfg_i,
  tafsm_sample_if.sink         sample_i,
  output logic                 push_o,
  output tafsm_pkg::cls_t      push_data_o,
  input  logic                 full_i
);

  logic                                enable_q;
  logic signed [tafsm_pkg::TempW-1:0]  high_critical_q;
  logic signed [tafsm_pkg::TempW-1:0]  high_warning_q;
  logic signed [tafsm_pkg::TempW-1:0]  low_critical_q;
  logic signed [tafsm_pkg::TempW-1:0]  low_warning_q;
  logic                                cfg_we;

  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q        <= 1'b0;
      high_critical_q <= tafsm_pkg::TempMax;
      high_warning_q  <= tafsm_pkg::TempMax;
      low_critical_q  <= tafsm_pkg::TempMin;
      low_warning_q   <= tafsm_pkg::TempMin;
    end else if (cfg_we) begin
      unique case (cfg_i.index)
        tafsm_pkg::CfgEnable:       enable_q        <= cfg_i.data[0];
        tafsm_pkg::CfgHighCritical: high_critical_q <= cfg_i.data;
        tafsm_pkg::CfgHighWarning:  high_warning_q  <= cfg_i.data;
        tafsm_pkg::CfgLowCritical:  low_critical_q  <= cfg_i.data;
        tafsm_pkg::CfgLowWarning:   low_warning_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // A sample is taken whenever the queue has room.
  assign sample_i.ready = !full_i;
  assign push_o         = sample_i.valid && !full_i;

  always_comb begin
    push_data_o.enable     = enable_q;
    push_data_o.above_lc   = sample_i.temperature >  low_critical_q;
    push_data_o.atmost_lw  = sample_i.temperature <= low_warning_q;
    push_data_o.below_hc   = sample_i.temperature <  high_critical_q;
    push_data_o.atleast_hw = sample_i.temperature >= high_warning_q;
  end

endmodule

// ----- sv/tafsm_queue.sv -----
module tafsm_queue #(
  parameter int DEPTH = tafsm_pkg::QueueDepthDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  tafsm_pkg::cls_t      push_data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output tafsm_pkg::cls_t      pop_data_o,
  output logic                 empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  tafsm_pkg::cls_t  mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign empty_o    = (count_q == '0);
  assign full_o     = (count_q == CntW'(DEPTH));
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/tafsm_back.sv -----
module tafsm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 empty_i,
  input  tafsm_pkg::cls_t      pop_data_i,
  output logic                 pop_o,
  tafsm_result_if.source       result_o
);

  logic [tafsm_pkg::StateW-1:0]  state_q, state_d;
  logic                          out_valid_q;
  tafsm_pkg::led_e               led_q, led_d;
  tafsm_pkg::event_e             ev_q, ev_d;
  tafsm_pkg::cls_t               c;

  assign c     = pop_data_i;
  assign pop_o = !empty_i && (!out_valid_q || result_o.ready);

  // One transition per sample; the first matching rule for the current state wins.
  always_comb begin
    state_d = state_q;
    led_d   = tafsm_pkg::LedNone;
    ev_d    = tafsm_pkg::EvNone;
    if (!c.enable) begin
      state_d = tafsm_pkg::StNorm1;
      led_d   = tafsm_pkg::LedOff;
    end else begin
      unique case (state_q)
        tafsm_pkg::StNorm1: begin
          if (c.above_lc && c.atmost_lw) begin
            state_d = tafsm_pkg::StWarnLo1;
            led_d   = tafsm_pkg::LedSlow;
            ev_d    = tafsm_pkg::EvLoWarn;
          end else if (c.below_hc && c.atleast_hw) begin
            state_d = tafsm_pkg::StWarnHi1;
            led_d   = tafsm_pkg::LedSlow;
            ev_d    = tafsm_pkg::EvHiWarn;
          end
        end
        tafsm_pkg::StNorm2: begin
          if (c.above_lc && c.atmost_lw) begin
            state_d = tafsm_pkg::StWarnLo1;
            led_d   = tafsm_pkg::LedSlow;
            ev_d    = tafsm_pkg::EvLoWarn;
          end
        end
        tafsm_pkg::StNorm3: begin
          if (c.below_hc && c.atleast_hw) begin
            state_d = tafsm_pkg::StWarnHi1;
            led_d   = tafsm_pkg::LedSlow;
            ev_d    = tafsm_pkg::EvHiWarn;
          end
        end
        tafsm_pkg::StWarnHi1: begin
          if (!c.below_hc) begin
            state_d = tafsm_pkg::StCritHi;
            led_d   = tafsm_pkg::LedFast;
            ev_d    = tafsm_pkg::EvHiAlarm;
          end
        end
        tafsm_pkg::StWarnHi2: begin
          if (!c.below_hc) begin
            state_d = tafsm_pkg::StCritHi;
            led_d   = tafsm_pkg::LedFast;
          end else if (!c.atleast_hw) begin
            state_d = tafsm_pkg::StNorm3;
            led_d   = tafsm_pkg::LedOff;
          end
        end
        tafsm_pkg::StWarnLo1: begin
          if (!c.above_lc) begin
            state_d = tafsm_pkg::StCritLo;
            led_d   = tafsm_pkg::LedFast;
            ev_d    = tafsm_pkg::EvLoAlarm;
          end
        end
        tafsm_pkg::StWarnLo2: begin
          // Falling back to critical low leaves the LED as it is.
          if (!c.above_lc) begin
            state_d = tafsm_pkg::StCritLo;
          end else if (!c.atmost_lw) begin
            state_d = tafsm_pkg::StNorm2;
            led_d   = tafsm_pkg::LedOff;
          end
        end
        tafsm_pkg::StCritLo: begin
          if (c.above_lc) begin
            state_d = tafsm_pkg::StWarnLo2;
            led_d   = tafsm_pkg::LedSlow;
            ev_d    = tafsm_pkg::EvLoWarn;
          end
        end
        tafsm_pkg::StCritHi: begin
          if (c.below_hc) begin
            state_d = tafsm_pkg::StWarnHi2;
            led_d   = tafsm_pkg::LedSlow;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tafsm_pkg::StNorm1;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      led_q <= led_d;
      ev_q  <= ev_d;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.led_command = led_q;
  assign result_o.event_code  = ev_q;
  assign result_o.alarm_state = state_q;

endmodule

// ----- sv/temperature_alarm_fsm.sv -----
// Temperature alarm with hysteresis. Each request on sample_i carries one signed
// 16-bit temperature and produces exactly one request on result_o with the new
// alarm state (normal 1 to 3, low and high warning 1 and 2, critical low and
// high), an LED command and an event code. The four thresholds and the enable
// bit are written through cfg_i, which is always ready; write them only while
// no sample is in flight. While enable is low every sample forces the LED off
// and returns the machine to normal 1. The block sustains one sample per clock
// cycle while result_o is not stalled and QUEUE_DEPTH is at least 2, set by the
// state update in the back end; each result passes through the queue and then
// the back end's output register. Up to QUEUE_DEPTH samples plus one finished
// result can be held while result_o is stalled.
module temperature_alarm_fsm #(
  parameter int QUEUE_DEPTH = tafsm_pkg::QueueDepthDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  tafsm_cfg_if.sink      cfg_i,
  tafsm_sample_if.sink   sample_i,
  tafsm_result_if.source result_o
);

  // The front end compares each sample against the thresholds and queues the
  // comparison flags together with the enable bit seen at that moment.
  logic            push;
  logic            full;
  logic            pop;
  logic            empty;
  tafsm_pkg::cls_t push_data;
  tafsm_pkg::cls_t pop_data;

  tafsm_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .sample_i    (sample_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // The queue lets the classifier keep taking samples while a result waits.
  tafsm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // The back end walks the alarm state machine in sample order and holds the
  // result in an output register until the consumer takes it.
  tafsm_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .pop_data_i (pop_data),
    .pop_o      (pop),
    .result_o   (result_o)
  );

endmodule

// ----- sv/tafsm_checker.sv -----
`include "assert_macros.svh"

module tafsm_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input tafsm_pkg::led_e               led_i,
  input tafsm_pkg::event_e             ev_i,
  input logic [tafsm_pkg::StateW-1:0]  state_i
);

  logic shown;
  logic has_event;
  logic led_blinks;
  logic hi_alarm;
  logic lo_alarm;
  logic alarm_lands;
  logic led_off;
  logic off_lands;

  assign shown       = out_valid_i;
  assign has_event   = shown && (ev_i != tafsm_pkg::EvNone);
  assign led_blinks  = (led_i == tafsm_pkg::LedSlow) || (led_i == tafsm_pkg::LedFast);
  assign hi_alarm    = (ev_i == tafsm_pkg::EvHiAlarm);
  assign lo_alarm    = (ev_i == tafsm_pkg::EvLoAlarm);
  assign alarm_lands = (hi_alarm && state_i == tafsm_pkg::StCritHi) ||
                       (lo_alarm && state_i == tafsm_pkg::StCritLo);
  assign led_off     = shown && (led_i == tafsm_pkg::LedOff);
  assign off_lands   = (ev_i == tafsm_pkg::EvNone) &&
                       (state_i == tafsm_pkg::StNorm1 || state_i == tafsm_pkg::StNorm2 ||
                        state_i == tafsm_pkg::StNorm3);

  // A result that is not taken stays offered.
  `TAF_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, shown && !out_ready_i, out_valid_i)

  // Any event comes with a blinking LED.
  `TAF_ASSERT_IMPL(a_event_blinks, clk_i, rst_ni, has_event, led_blinks)

  // An alarm event lands in the matching critical state.
  `TAF_ASSERT_IMPL(a_alarm_state, clk_i, rst_ni, shown && (hi_alarm || lo_alarm), alarm_lands)

  // Turning the LED off only happens on the way to a normal state.
  `TAF_ASSERT_IMPL(a_off_normal, clk_i, rst_ni, led_off, off_lands)

endmodule

bind temperature_alarm_fsm tafsm_checker u_tafsm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (result_o.valid),
  .out_ready_i (result_o.ready),
  .led_i       (result_o.led_command),
  .ev_i        (result_o.event_code),
  .state_i     (result_o.alarm_state)
);
